// ===== hdl/pcat_pkg.sv =====
// Package with constants, codes and types shared by the channel allocation table.
package pcat_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int DUTY_BITS  = 13;
  localparam int PIN_BITS   = 6;

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CHAN_W = 3;
  localparam int DUTY_W = 13;
  localparam int TMR_W  = 3;
  localparam int LVL_W  = 8;
  localparam int PROD_W = LVL_W + DUTY_BITS;
  localparam int SAT_W  = (DUTY_W > DUTY_BITS) ? DUTY_W : DUTY_BITS;

  localparam logic [TMR_W-1:0]     TIMER_NONE  = 3'd4;
  localparam logic [TMR_W-1:0]     LEVEL_TIMER = 3'd0;
  localparam logic [LVL_W-1:0]     LEVEL_MAX   = 8'd255;
  localparam logic [DUTY_BITS-1:0] DUTY_MAX    = '1;

  typedef enum logic [1:0] {
    CMD_ACQUIRE  = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_SET_DUTY = 2'd2,
    CMD_SET_LVL  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_HELD = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic                valid;
    logic [PIN_BITS-1:0] pin;
    logic [IDX_W-1:0]    pos;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [TMR_W-1:0]    hit_timer;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
  } tok_t;

  typedef struct packed {
    logic                used;
    logic [PIN_BITS-1:0] pin;
    logic [TMR_W-1:0]    timer;
  } slot_wr_t;

endpackage

// ===== hdl/pcat_cell.sv =====
// One slot of the table, which also adds its own lookup result to the passing search token.
module pcat_cell
  import pcat_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tok_t     tok_i,
  input  logic     we_i,
  input  slot_wr_t wr_i,
  output tok_t     tok_o
);

  logic                used_q;
  logic [PIN_BITS-1:0] pin_q;
  logic [TMR_W-1:0]    timer_q;
  tok_t                tok_d;
  tok_t                tok_q;
  logic                hit_here;

  always_comb begin
    hit_here  = used_q && (pin_q == tok_i.pin);
    tok_d     = tok_i;
    tok_d.pos = tok_i.pos + IDX_W'(1);
    if (!tok_i.hit && hit_here) begin
      tok_d.hit       = 1'b1;
      tok_d.hit_idx   = tok_i.pos;
      tok_d.hit_timer = timer_q;
    end
    if (!tok_i.free_found && !used_q) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = tok_i.pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      pin_q   <= '0;
      timer_q <= TIMER_NONE;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (we_i) begin
        used_q  <= wr_i.used;
        pin_q   <= wr_i.pin;
        timer_q <= wr_i.timer;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/pcat_duty.sv =====
// Level to duty conversion, floor(level * duty maximum / 255), over two register stages.
module pcat_duty
  import pcat_pkg::*;
(
  input  logic                 clk_i,
  input  logic [LVL_W-1:0]     lvl_i,
  output logic [DUTY_BITS-1:0] duty_o
);

  localparam int M_W = PROD_W + 9;

  logic [PROD_W-1:0]    prod_q;
  logic [DUTY_BITS-1:0] qest_q;
  logic [M_W-1:0]       recip;
  logic [PROD_W-1:0]    back;
  logic [PROD_W-1:0]    rem;

  always_comb begin
    recip  = (M_W'(prod_q) << 8) + M_W'(prod_q);
    back   = (PROD_W'(qest_q) << 8) - PROD_W'(qest_q);
    rem    = prod_q - back;
    duty_o = (rem >= PROD_W'(LEVEL_MAX)) ? qest_q + DUTY_BITS'(1) : qest_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(lvl_i) * PROD_W'(DUTY_MAX);
    qest_q <= DUTY_BITS'(recip >> 16);
  end

endmodule

// ===== hdl/pwm_channel_allocation_table_core.sv =====
// Top level of the PWM channel allocation table: request control, slot chain and result register.
//
// Usage: a request (command, pin, timer_id, duty_raw, level) is accepted at a
// rising edge where in_valid_i is high and in_stall_o is low. The block works
// on one request at a time and holds in_stall_o high until its result has been
// taken. A search token enters the first slot cell and moves one cell per
// cycle along the SLOT_COUNT cells, collecting the pin's slot and the lowest
// free slot. The control then updates the chosen slot and loads the result
// register, after which out_valid_o rises. The next request can be accepted in
// the cycle after the result is taken. While out_stall_i is high the result
// stays on the output ports unchanged. Reset frees every slot, sets each slot's
// timer to none and empties the block; no result is pending after reset.
module pwm_channel_allocation_table_core
  import pcat_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [5:0]         pin_i,
  input  logic [1:0]         timer_id_i,
  input  logic [12:0]        duty_raw_i,
  input  logic signed [10:0] level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [2:0]         channel_o,
  output logic               setup_issued_o,
  output logic               duty_write_o,
  output logic [12:0]        duty_value_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESOLVE,
    S_OUT
  } state_e;

  state_e               state_q;
  cmd_e                 cmd_q;
  logic [TMR_W-1:0]     timer_q;
  logic [DUTY_W-1:0]    duty_q;
  logic [LVL_W-1:0]     lvl_q;
  logic [LVL_W-1:0]     lvl_d;
  tok_t                 res_q;
  tok_t                 tok_in;
  tok_t                 chain [SLOT_COUNT+1];
  logic [DUTY_BITS-1:0] lvl_duty;
  logic                 accept;

  logic [1:0]           status_q;
  logic [CHAN_W-1:0]    channel_q;
  logic                 setup_q;
  logic                 wr_q;
  logic [DUTY_W-1:0]    value_q;

  logic [1:0]           r_status;
  logic [IDX_W-1:0]     r_idx;
  logic                 r_setup;
  logic                 r_wr;
  logic [DUTY_BITS-1:0] r_value;
  logic                 r_we;
  slot_wr_t             r_slot;
  logic [TMR_W-1:0]     want_tmr;
  logic [DUTY_BITS-1:0] sat_duty;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    tok_in       = '0;
    tok_in.valid = accept;
    tok_in.pin   = PIN_BITS'(pin_i);
    if (level_i[10]) begin
      lvl_d = '0;
    end else if (level_i[9:8] != 2'b00) begin
      lvl_d = LEVEL_MAX;
    end else begin
      lvl_d = level_i[7:0];
    end
  end

  assign chain[0] = tok_in;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
    pcat_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[i]),
      .we_i   (r_we && (r_idx == IDX_W'(i))),
      .wr_i   (r_slot),
      .tok_o  (chain[i+1])
    );
  end

  pcat_duty u_duty (
    .clk_i  (clk_i),
    .lvl_i  (lvl_q),
    .duty_o (lvl_duty)
  );

  always_comb begin
    want_tmr = (cmd_q == CMD_ACQUIRE) ? timer_q : LEVEL_TIMER;
    sat_duty = (SAT_W'(duty_q) > SAT_W'(DUTY_MAX)) ? DUTY_MAX : DUTY_BITS'(duty_q);
    r_status = ST_OK;
    r_idx    = '0;
    r_setup  = 1'b0;
    r_wr     = 1'b0;
    r_value  = '0;
    r_we     = 1'b0;
    r_slot   = '{used: 1'b1, pin: res_q.pin, timer: want_tmr};
    case (cmd_q)
      CMD_ACQUIRE, CMD_SET_LVL: begin
        if (res_q.hit) begin
          r_idx   = res_q.hit_idx;
          r_setup = (res_q.hit_timer != want_tmr);
          r_we    = r_setup;
        end else if (res_q.free_found) begin
          r_idx   = res_q.free_idx;
          r_setup = 1'b1;
          r_we    = 1'b1;
        end else begin
          r_status = ST_FULL;
        end
        if (cmd_q == CMD_SET_LVL && r_status == ST_OK) begin
          r_wr    = 1'b1;
          r_value = lvl_duty;
        end
      end
      CMD_RELEASE: begin
        r_slot = '{used: 1'b0, pin: '0, timer: TIMER_NONE};
        if (res_q.hit) begin
          r_idx = res_q.hit_idx;
          r_we  = 1'b1;
        end else begin
          r_status = ST_NOT_HELD;
        end
      end
      CMD_SET_DUTY: begin
        if (res_q.hit) begin
          r_idx   = res_q.hit_idx;
          r_wr    = 1'b1;
          r_value = sat_duty;
        end else begin
          r_status = ST_NOT_HELD;
        end
      end
      default: begin
        r_status = ST_OK;
      end
    endcase
    r_we = r_we && (state_q == S_RESOLVE);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      timer_q <= TMR_W'(timer_id_i);
      duty_q  <= duty_raw_i;
      lvl_q   <= lvl_d;
    end
    if (state_q == S_WALK && chain[SLOT_COUNT].valid) begin
      res_q <= chain[SLOT_COUNT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      status_q  <= '0;
      channel_q <= '0;
      setup_q   <= 1'b0;
      wr_q      <= 1'b0;
      value_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (chain[SLOT_COUNT].valid) begin
            state_q <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          status_q  <= r_status;
          channel_q <= CHAN_W'(r_idx);
          setup_q   <= r_setup;
          wr_q      <= r_wr;
          value_q   <= DUTY_W'(r_value);
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = (state_q == S_OUT);
  assign status_o       = status_q;
  assign channel_o      = channel_q;
  assign setup_issued_o = setup_q;
  assign duty_write_o   = wr_q;
  assign duty_value_o   = value_q;

endmodule
